>>> design/dpl_pkg.sv
// ----------------------------------------------------------------------------
// DNS payload locator package
// Shared types and constants for the DNS payload locator.
// ----------------------------------------------------------------------------
package dpl_pkg;

    localparam int unsigned DataWidth   = 8;
    localparam int unsigned CountWidth  = 16;
    localparam int unsigned PortWidth   = 16;
    localparam int unsigned OffsetWidth = 7;
    localparam int unsigned ResultWidth = 32;

    localparam logic [PortWidth-1:0]  DnsPortReset  = 16'd53;
    localparam logic [3:0]            VersionIpv4   = 4'd4;
    localparam logic [3:0]            VersionIpv6   = 4'd6;
    localparam logic [5:0]            Ipv6HdrBytes  = 6'd40;
    localparam logic [CountWidth:0]   Ipv6MinPacket = 17'd48;
    localparam logic [CountWidth:0]   Ipv4MinHdr    = 17'd20;
    localparam logic [CountWidth:0]   MinPacket     = 17'd20;
    localparam logic [7:0]            ProtoTcp      = 8'd6;
    localparam logic [CountWidth:0]   DnsMinBytes   = 17'd12;
    localparam logic [3:0]            TcpMinWords   = 4'd5;
    localparam logic [CountWidth-1:0] CountMax      = 16'hFFFF;

    // Per-packet header state.
    typedef struct packed {
        logic [3:0]           version;
        logic [5:0]           ts;
        logic [7:0]           proto;
        logic [PortWidth-1:0] sport;
        logic [3:0]           thw;
        logic [15:0]          tlen;
    } pkt_state_t;

    // One verdict.
    typedef struct packed {
        logic [15:0]            length;
        logic [OffsetWidth-1:0] offset;
        logic                   over_tcp;
        logic                   found;
    } verdict_t;

endpackage

>>> design/dns_payload_locator.sv
// ----------------------------------------------------------------------------
// DNS payload locator
// Finds a DNS message inside an IPv4/IPv6 UDP or TCP packet streamed bytewise.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one packet byte per transfer in s_tdata, starting
//   at the first IP header byte, with s_tlast on the final byte. For every
//   packet one verdict transfer leaves on the m_ channel after its last byte.
//   cfg_wr_en/cfg_wr_data set the DNS source port (reset value 53); write it
//   only while no packet is in flight.
// Timing:
//   Every byte passes an input register and is captured into the header
//   state in the next cycle; a packet's verdict is registered onto m_.
//   One byte is taken per cycle unless a last byte waits for the verdict
//   slot; the single header-capture and verdict stage sets that rate.
// Reset and stalls:
//   aresetn (synchronous, active low) clears the byte counter, header state
//   and both valid flags. While a verdict waits on m_tready, bytes that are
//   not the last of a packet keep flowing; a last byte waits in the input
//   register until the verdict slot frees.
// ----------------------------------------------------------------------------
module dns_payload_locator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [dpl_pkg::PortWidth-1:0] cfg_wr_data,
    // s_tdata: [7:0] data_byte
    input  logic [dpl_pkg::DataWidth-1:0] s_tdata,
    input  logic                          s_tlast,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // m_tdata: [0] found, [1] over_tcp, [8:2] payload_offset,
    //          [24:9] payload_length, [31:25] zero
    output logic [dpl_pkg::ResultWidth-1:0] m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready
);
    import dpl_pkg::*;

    logic [PortWidth-1:0]  port_reg;
    logic                  in_vld_reg;
    logic [DataWidth-1:0]  in_byte_reg;
    logic                  in_last_reg;
    logic [CountWidth-1:0] cnt_reg, cnt_next;
    pkt_state_t            st_reg, st_cap, st_next;
    verdict_t              res_reg, res_next;
    logic                  m_vld_reg;
    logic                  out_free, proc;

    assign out_free = !m_vld_reg || m_tready;
    assign proc     = in_vld_reg && (!in_last_reg || out_free);
    assign s_tready = !in_vld_reg || proc;
    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {{(ResultWidth - $bits(verdict_t)){1'b0}}, res_reg};

    // Header capture for the byte held in the input register.
    always_comb begin
        logic [6:0] len_pos;
        st_cap  = st_reg;
        len_pos = 7'(st_reg.ts) + {1'b0, st_reg.thw, 2'b00};
        if (cnt_reg == '0) begin
            st_cap.version = in_byte_reg[7:4];
            if (in_byte_reg[7:4] == VersionIpv4) begin
                st_cap.ts = {in_byte_reg[3:0], 2'b00};
            end else if (in_byte_reg[7:4] == VersionIpv6) begin
                st_cap.ts = Ipv6HdrBytes;
            end else begin
                st_cap.ts = '0;
            end
        end else begin
            if ((st_reg.version == VersionIpv4 && cnt_reg == 16'd9) ||
                (st_reg.version == VersionIpv6 && cnt_reg == 16'd6)) begin
                st_cap.proto = in_byte_reg;
            end
            if (cnt_reg == 16'(st_reg.ts)) begin
                st_cap.sport[15:8] = in_byte_reg;
            end
            if (cnt_reg == 16'(st_reg.ts) + 16'd1) begin
                st_cap.sport[7:0] = in_byte_reg;
            end
            if (cnt_reg == 16'(st_reg.ts) + 16'd12) begin
                st_cap.thw = in_byte_reg[7:4];
            end
            if (st_reg.thw >= TcpMinWords && cnt_reg == 16'(len_pos)) begin
                st_cap.tlen[15:8] = in_byte_reg;
            end
            if (st_reg.thw >= TcpMinWords && cnt_reg == 16'(len_pos) + 16'd1) begin
                st_cap.tlen[7:0] = in_byte_reg;
            end
        end
    end

    // Verdict on the captured state; only used on a last byte.
    always_comb begin
        logic [CountWidth:0] pkt;
        logic [CountWidth:0] ts;
        logic [CountWidth:0] start;
        logic [CountWidth:0] n;
        logic                ok;
        logic                tcp;
        pkt   = (cnt_reg == CountMax) ? 17'(CountMax) : 17'(cnt_reg) + 17'd1;
        ts    = 17'(st_cap.ts);
        ok    = 1'b1;
        tcp   = 1'b0;
        start = '0;
        n     = '0;
        if (pkt < MinPacket) begin
            ok = 1'b0;
        end
        if (st_cap.version == VersionIpv4) begin
            if (ts < Ipv4MinHdr || pkt < ts + 17'd8) begin
                ok = 1'b0;
            end
        end else if (st_cap.version == VersionIpv6) begin
            if (pkt < Ipv6MinPacket) begin
                ok = 1'b0;
            end
        end else begin
            ok = 1'b0;
        end
        if (pkt < ts + 17'd8 || st_cap.sport != port_reg) begin
            ok = 1'b0;
        end
        if (st_cap.proto == ProtoTcp) begin
            tcp   = 1'b1;
            start = ts + 17'({st_cap.thw, 2'b00}) + 17'd2;
            if (pkt < ts + 17'd13 || st_cap.thw < TcpMinWords ||
                pkt < start + DnsMinBytes) begin
                ok = 1'b0;
            end
            if (start + 17'(st_cap.tlen) > pkt) begin
                n = pkt - start;
            end else begin
                n = 17'(st_cap.tlen);
            end
        end else begin
            start = ts + 17'd8;
            if (pkt <= start) begin
                ok = 1'b0;
            end
            n = pkt - start;
        end
        if (n < DnsMinBytes) begin
            ok = 1'b0;
        end
        res_next.found    = ok;
        res_next.over_tcp = ok && tcp;
        res_next.offset   = ok ? start[OffsetWidth-1:0] : '0;
        res_next.length   = ok ? n[15:0] : '0;
    end

    always_comb begin
        if (in_last_reg) begin
            st_next  = '0;
            cnt_next = '0;
        end else begin
            st_next  = st_cap;
            cnt_next = (cnt_reg == CountMax) ? cnt_reg : cnt_reg + 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_reg   <= DnsPortReset;
            in_vld_reg <= 1'b0;
            cnt_reg    <= '0;
            st_reg     <= '0;
            m_vld_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                port_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (proc) begin
                cnt_reg <= cnt_next;
                st_reg  <= st_next;
            end
            if (proc && in_last_reg) begin
                m_vld_reg <= 1'b1;
            end else if (m_tready) begin
                m_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (proc && in_last_reg) begin
            res_reg <= res_next;
        end
    end

    // A verdict without a payload carries no offset, length or TCP flag.
    a_notfound_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_vld_reg && !res_reg.found |-> res_reg[$bits(verdict_t)-1:1] == '0)
        else $error("verdict not found but payload fields set");

    // A located payload is always at least a DNS header long.
    a_found_min_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_vld_reg && res_reg.found |-> res_reg.length >= 16'd12)
        else $error("located payload shorter than a DNS header");

    // A TCP payload sits behind at least a minimal IP and TCP header.
    a_tcp_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_vld_reg && res_reg.over_tcp |-> res_reg.offset >= 7'd42)
        else $error("TCP payload offset inside headers");

    // The packet state starts over after a last byte.
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && in_last_reg |=> cnt_reg == '0 && st_reg == '0)
        else $error("packet state not cleared after last byte");

    // A held last byte is not dropped while the verdict slot is busy.
    a_hold_last: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && in_last_reg && !out_free |=> in_vld_reg && in_last_reg)
        else $error("last byte lost while output stalled");

endmodule
